@@ sv/pixel_neighbour_enumerator_defines.svh @@
// ----------------------------------------------------------------------------
// pixel_neighbour_enumerator_defines.svh
// Assertion macros for the neighbour enumerator RTL.
// ----------------------------------------------------------------------------
`ifndef PIXEL_NEIGHBOUR_ENUMERATOR_DEFINES_SVH
`define PIXEL_NEIGHBOUR_ENUMERATOR_DEFINES_SVH

`ifndef ASSERT_OFF
// antecedent in a cycle implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// antecedent in a cycle implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ sv/pne_pkg.sv @@
// ----------------------------------------------------------------------------
// pne_pkg
// Types, codes and helpers for the pixel neighbour enumerator.
// ----------------------------------------------------------------------------
package pne_pkg;

  // configuration register index
  typedef enum logic [1:0] {
    REG_CHIPS_PER_SENSOR = 2'd0,
    REG_COLUMNS_PER_CHIP = 2'd1,
    REG_ROWS_PER_CHIP    = 2'd2
  } reg_idx_e;

  // neighbour slots in emission order
  typedef enum logic [2:0] {
    SLOT_BELOW       = 3'd0,
    SLOT_ABOVE       = 3'd1,
    SLOT_LEFT        = 3'd2,
    SLOT_LEFT_BELOW  = 3'd3,
    SLOT_LEFT_ABOVE  = 3'd4,
    SLOT_RIGHT       = 3'd5,
    SLOT_RIGHT_BELOW = 3'd6,
    SLOT_RIGHT_ABOVE = 3'd7
  } nbr_slot_e;

  localparam int unsigned NUM_SLOTS = 8;

  // one seed with all candidate neighbour coordinates resolved
  typedef struct packed {
    logic [5:0]           module_id;
    logic [5:0]           chip_id;
    logic [7:0]           column;
    logic [7:0]           row_dn;
    logic [7:0]           row_ctr;
    logic [7:0]           row_up;
    logic [5:0]           chip_l;
    logic [7:0]           col_l;
    logic [5:0]           chip_r;
    logic [7:0]           col_r;
    logic [NUM_SLOTS-1:0] mask;
  } nbr_item_t;

  // one restoring step of chip modulo chips-per-sensor
  function automatic logic [4:0] mod_step(input logic [4:0] rem, input logic din,
                                          input logic [4:0] nchips);
    logic [5:0] t;
    t = {rem, din};
    if (t >= {1'b0, nchips}) begin
      t = t - {1'b0, nchips};
    end
    return t[4:0];
  endfunction

endpackage

@@ sv/pne_emitter.sv @@
// ----------------------------------------------------------------------------
// pne_emitter
// Holds one resolved seed and sends its existing neighbours, marking the final
// one, through an output register one word per cycle while m_axis is ready.
// ----------------------------------------------------------------------------
module pne_emitter
  import pne_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_valid_i,
  output logic        load_ready_o,
  input  nbr_item_t   item_i,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [5:0] neighbour_module, [11:6] neighbour_chip, [19:12] neighbour_column,
  // [27:20] neighbour_row, [31:28] zero
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  logic                 em_valid_q, em_valid_d;
  nbr_item_t            em_item_q, em_item_d;
  logic                 out_valid_q, out_valid_d;
  logic [27:0]          out_data_q, out_data_d;
  logic                 out_last_q, out_last_d;
  logic                 out_free, fire;
  nbr_slot_e            sel;
  logic [NUM_SLOTS-1:0] onehot, rest;
  logic [5:0]           sel_chip;
  logic [7:0]           sel_col, sel_row;

  assign out_free = !out_valid_q || m_axis_tready;
  assign fire     = em_valid_q && out_free;

  // lowest pending slot goes next
  always_comb begin
    sel = SLOT_RIGHT_ABOVE;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (em_item_q.mask[i]) begin
        sel = nbr_slot_e'(3'(i));
      end
    end
  end

  assign onehot = NUM_SLOTS'(1) << sel;
  assign rest   = em_item_q.mask & ~onehot;
  assign load_ready_o = !em_valid_q || (fire && (rest == '0));

  always_comb begin
    unique case (sel)
      SLOT_BELOW: begin
        sel_chip = em_item_q.chip_id; sel_col = em_item_q.column; sel_row = em_item_q.row_dn;
      end
      SLOT_ABOVE: begin
        sel_chip = em_item_q.chip_id; sel_col = em_item_q.column; sel_row = em_item_q.row_up;
      end
      SLOT_LEFT: begin
        sel_chip = em_item_q.chip_l; sel_col = em_item_q.col_l; sel_row = em_item_q.row_ctr;
      end
      SLOT_LEFT_BELOW: begin
        sel_chip = em_item_q.chip_l; sel_col = em_item_q.col_l; sel_row = em_item_q.row_dn;
      end
      SLOT_LEFT_ABOVE: begin
        sel_chip = em_item_q.chip_l; sel_col = em_item_q.col_l; sel_row = em_item_q.row_up;
      end
      SLOT_RIGHT: begin
        sel_chip = em_item_q.chip_r; sel_col = em_item_q.col_r; sel_row = em_item_q.row_ctr;
      end
      SLOT_RIGHT_BELOW: begin
        sel_chip = em_item_q.chip_r; sel_col = em_item_q.col_r; sel_row = em_item_q.row_dn;
      end
      SLOT_RIGHT_ABOVE: begin
        sel_chip = em_item_q.chip_r; sel_col = em_item_q.col_r; sel_row = em_item_q.row_up;
      end
      default: begin
        sel_chip = em_item_q.chip_id; sel_col = em_item_q.column; sel_row = em_item_q.row_ctr;
      end
    endcase
  end

  always_comb begin
    em_valid_d  = em_valid_q;
    em_item_d   = em_item_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    if (load_valid_i && load_ready_o) begin
      // a seed with no neighbours is dropped here
      em_valid_d = |item_i.mask;
      em_item_d  = item_i;
    end else if (fire) begin
      em_valid_d     = |rest;
      em_item_d.mask = rest;
    end
    if (fire) begin
      out_valid_d = 1'b1;
      out_data_d  = {sel_row, sel_col, sel_chip, em_item_q.module_id};
      out_last_d  = (rest == '0);
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      em_valid_q  <= em_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    em_item_q  <= em_item_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_data_q};
  assign m_axis_tlast  = out_last_q;

endmodule

@@ sv/pixel_neighbour_enumerator.sv @@
// ----------------------------------------------------------------------------
// pixel_neighbour_enumerator
// Lists the existing 8-connected neighbours of a seed pixel, crossing into
// the adjacent chip of the same sensor at a chip's first or last column.
// ----------------------------------------------------------------------------
// channel   dir  handshake                   word
// s_axis    in   tvalid/tready               module, chip, column, row
// m_axis    out  tvalid/tready, tlast        neighbour module, chip, column, row
// apb       in   psel/penable/pwrite/pready  chips, columns, rows per chip
//
// three register stages: seed and first half of chip modulo, resolved seed
// in the emitter, output register; the emitter holds a seed until the last
// of its neighbour words (0 to 8) is sent and takes the next seed only then,
// so it sets the sustained seed rate
// a stall on m_axis holds the output word and backs up the stages in order
// reset empties all stages and loads 3, 256, 256 into the registers
// ----------------------------------------------------------------------------
`include "pixel_neighbour_enumerator_defines.svh"

module pixel_neighbour_enumerator
  import pne_pkg::*;
#(
  parameter int unsigned MAX_COLUMNS = 256,
  parameter int unsigned MAX_ROWS    = 256,
  parameter int unsigned MAX_CHIPS   = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [5:0] module_id, [11:6] chip_id, [19:12] column, [27:20] row_index,
  // [31:28] unused
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [5:0] neighbour_module, [11:6] neighbour_chip, [19:12] neighbour_column,
  // [27:20] neighbour_row, [31:28] zero
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration
  logic [4:0] cps_q;
  logic [8:0] cpc_q, rpc_q;
  logic [4:0] nchips;
  logic [8:0] last_col, last_row;
  reg_idx_e   reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cps_q <= 5'd3;
      cpc_q <= 9'd256;
      rpc_q <= 9'd256;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_CHIPS_PER_SENSOR: cps_q <= pwdata[4:0];
        REG_COLUMNS_PER_CHIP: cpc_q <= pwdata[8:0];
        REG_ROWS_PER_CHIP:    rpc_q <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CHIPS_PER_SENSOR: prdata = {27'b0, cps_q};
      REG_COLUMNS_PER_CHIP: prdata = {23'b0, cpc_q};
      REG_ROWS_PER_CHIP:    prdata = {23'b0, rpc_q};
      default:              prdata = 32'b0;
    endcase
  end

  // zero acts as one, oversized values saturate at the maximum
  always_comb begin
    if (cps_q == '0) begin
      nchips = 5'd1;
    end else if (32'(cps_q) > 32'(MAX_CHIPS)) begin
      nchips = 5'(MAX_CHIPS);
    end else begin
      nchips = cps_q;
    end
    if (cpc_q == '0) begin
      last_col = 9'd0;
    end else if (32'(cpc_q) > 32'(MAX_COLUMNS)) begin
      last_col = 9'(MAX_COLUMNS - 1);
    end else begin
      last_col = cpc_q - 9'd1;
    end
    if (rpc_q == '0) begin
      last_row = 9'd0;
    end else if (32'(rpc_q) > 32'(MAX_ROWS)) begin
      last_row = 9'(MAX_ROWS - 1);
    end else begin
      last_row = rpc_q - 9'd1;
    end
  end

  // stage a: seed, row and column flags, upper half of the modulo
  logic       a_valid_q;
  logic [5:0] a_mod_q, a_chip_q;
  logic [7:0] a_col_q, a_row_q;
  logic [4:0] a_rem_q, a_rem_d;
  logic       a_hb_q, a_ha_q, a_col_nz_q, a_col_lt_q;
  logic       a_ready, em_ready;
  logic       s_fire;
  logic [5:0] in_chip;
  logic [7:0] in_col, in_row;

  assign in_chip       = s_axis_tdata[11:6];
  assign in_col        = s_axis_tdata[19:12];
  assign in_row        = s_axis_tdata[27:20];
  assign a_ready       = !a_valid_q || em_ready;
  assign s_axis_tready = a_ready;
  assign s_fire        = s_axis_tvalid && a_ready;

  always_comb begin
    a_rem_d = '0;
    for (int i = 5; i >= 3; i--) begin
      a_rem_d = mod_step(a_rem_d, in_chip[i], nchips);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      a_mod_q    <= s_axis_tdata[5:0];
      a_chip_q   <= in_chip;
      a_col_q    <= in_col;
      a_row_q    <= in_row;
      a_rem_q    <= a_rem_d;
      a_hb_q     <= (in_row != '0);
      a_ha_q     <= ({1'b0, in_row} < last_row);
      a_col_nz_q <= (in_col != '0);
      a_col_lt_q <= ({1'b0, in_col} < last_col);
    end
  end

  // lower half of the modulo and side resolution
  logic [4:0] pos;
  logic       pos_last, has_l, has_r;
  nbr_item_t  item;

  always_comb begin
    pos = a_rem_q;
    for (int i = 2; i >= 0; i--) begin
      pos = mod_step(pos, a_chip_q[i], nchips);
    end
  end

  assign pos_last = ({1'b0, pos} + 6'd1) >= {1'b0, nchips};
  assign has_l    = a_col_nz_q || (pos != '0);
  assign has_r    = a_col_lt_q || !pos_last;

  always_comb begin
    item.module_id = a_mod_q;
    item.chip_id   = a_chip_q;
    item.column    = a_col_q;
    item.row_dn    = a_row_q - 8'd1;
    item.row_ctr   = a_row_q;
    item.row_up    = a_row_q + 8'd1;
    item.chip_l    = a_col_nz_q ? a_chip_q : a_chip_q - 6'd1;
    item.col_l     = a_col_nz_q ? a_col_q - 8'd1 : last_col[7:0];
    item.chip_r    = a_col_lt_q ? a_chip_q : a_chip_q + 6'd1;
    item.col_r     = a_col_lt_q ? a_col_q + 8'd1 : 8'd0;
    item.mask      = '0;
    item.mask[SLOT_BELOW]       = a_hb_q;
    item.mask[SLOT_ABOVE]       = a_ha_q;
    item.mask[SLOT_LEFT]        = has_l;
    item.mask[SLOT_LEFT_BELOW]  = has_l && a_hb_q;
    item.mask[SLOT_LEFT_ABOVE]  = has_l && a_ha_q;
    item.mask[SLOT_RIGHT]       = has_r;
    item.mask[SLOT_RIGHT_BELOW] = has_r && a_hb_q;
    item.mask[SLOT_RIGHT_ABOVE] = has_r && a_ha_q;
  end

  pne_emitter u_emitter (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_valid_i  (a_valid_q),
    .load_ready_o  (em_ready),
    .item_i        (item),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // partial remainder always stays below the divisor
  `ASSERT_IMPLY(a_rem_bound, clk_i, rst_ni, a_valid_q, a_rem_q < nchips)
  // a stalled seed in stage a is held intact
  `ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, a_valid_q && !em_ready,
               a_valid_q && $stable(a_chip_q) && $stable(a_rem_q) && $stable(a_row_q))
  // stage a never takes a word while it still holds one that is stuck
  `ASSERT_IMPLY(a_no_overrun, clk_i, rst_ni, a_valid_q && !em_ready, !s_axis_tready)

endmodule

@@ tb/pixel_neighbour_enumerator_tb.sv @@
// ----------------------------------------------------------------------------
// pixel_neighbour_enumerator_tb
// Streams seed pixels into the neighbour enumerator under several register
// settings and compares every neighbour word, in order, against a local
// prediction of the 8-neighbourhood; both stream sides idle at random.
// ----------------------------------------------------------------------------
module pixel_neighbour_enumerator_tb
  import pne_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_COLUMNS  = 256;
  localparam int unsigned MAX_ROWS     = 256;
  localparam int unsigned MAX_CHIPS    = 64;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned RAND_PHASES  = 6;
  localparam int unsigned PHASE_SEEDS  = 56;
  localparam logic [1:0]  REG_UNUSED   = 2'd3;
  localparam logic [4:0]  RST_CHIPS    = 5'd3;
  localparam logic [8:0]  RST_COLUMNS  = 9'd256;
  localparam logic [8:0]  RST_ROWS     = 9'd256;

  typedef struct packed {
    logic [7:0] row;
    logic [7:0] col;
    logic [5:0] chip;
    logic [5:0] mod;
  } seed_t;

  typedef struct {
    logic [5:0] mod;
    logic [5:0] chip;
    logic [7:0] col;
    logic [7:0] row;
    logic       is_last;
  } nbr_word_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [5:0] module_id, [11:6] chip_id, [19:12] column, [27:20] row_index
  logic [31:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [5:0] module, [11:6] chip, [19:12] column, [27:20] row, [31:28] zero
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [3:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  // local copy of the register file
  logic [4:0] cfg_chips = RST_CHIPS;
  logic [8:0] cfg_cols  = RST_COLUMNS;
  logic [8:0] cfg_rows  = RST_ROWS;

  seed_t       seed_q[$];
  nbr_word_t   nbr_expect_q[$];
  seed_t       cur_seed;
  logic        seed_pending = 1'b0;
  logic        no_idle      = 1'b0;
  logic        hold_req     = 1'b0;
  int unsigned src_gap      = 0;
  int unsigned sink_gap     = 0;
  int unsigned hold_left    = 0;
  int unsigned error_count  = 0;
  int unsigned seeds_taken  = 0;
  int unsigned words_seen   = 0;
  int unsigned settings_cnt = 0;

  pixel_neighbour_enumerator #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS),
    .MAX_CHIPS  (MAX_CHIPS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #10 clk_i = ~clk_i;

  // zero acts as one, oversize acts as the maximum
  function automatic int unsigned cfg_clamp(int unsigned v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic nbr_word_t nbr_of(logic [5:0] m, logic [5:0] c, logic [7:0] col,
                                       logic [7:0] row);
    nbr_word_t w;
    w.mod     = m;
    w.chip    = c;
    w.col     = col;
    w.row     = row;
    w.is_last = 1'b0;
    return w;
  endfunction

  function automatic seed_t seed_of(logic [5:0] m, logic [5:0] c, logic [7:0] col,
                                    logic [7:0] row);
    seed_t s;
    s.mod  = m;
    s.chip = c;
    s.col  = col;
    s.row  = row;
    return s;
  endfunction

  // appends one seed to the pending queue
  function automatic void add_seed(seed_t s);
    seed_q.insert(seed_q.size(), s);
  endfunction

  // lists the existing neighbours of one seed into the expectation queue
  function automatic void predict_neighbours(seed_t sd);
    int unsigned nchips, last_col, last_row, pos, ncol;
    logic [5:0]  nchip;
    logic        below, above, exists;
    nbr_word_t   words[$];
    nchips   = cfg_clamp(32'(cfg_chips), MAX_CHIPS);
    last_col = cfg_clamp(32'(cfg_cols), MAX_COLUMNS) - 1;
    last_row = cfg_clamp(32'(cfg_rows), MAX_ROWS) - 1;
    pos      = sd.chip % nchips;
    below    = sd.row > 0;
    above    = sd.row < last_row;
    if (below) words = {words, nbr_of(sd.mod, sd.chip, sd.col, sd.row - 8'd1)};
    if (above) words = {words, nbr_of(sd.mod, sd.chip, sd.col, sd.row + 8'd1)};
    for (int side = 0; side < 2; side++) begin
      exists = 1'b1;
      nchip  = sd.chip;
      ncol   = 0;
      if (side == 0) begin
        if (sd.col > 0) begin
          ncol = sd.col - 1;
        end else if (pos > 0) begin
          nchip = sd.chip - 6'd1;
          ncol  = last_col;
        end else begin
          exists = 1'b0;
        end
      end else begin
        if (sd.col < last_col) begin
          ncol = sd.col + 1;
        end else if (pos < nchips - 1) begin
          // next chip number wraps within 6 bits
          nchip = sd.chip + 6'd1;
          ncol  = 0;
        end else begin
          exists = 1'b0;
        end
      end
      if (exists) begin
        words = {words, nbr_of(sd.mod, nchip, ncol[7:0], sd.row)};
        if (below) words = {words, nbr_of(sd.mod, nchip, ncol[7:0], sd.row - 8'd1)};
        if (above) words = {words, nbr_of(sd.mod, nchip, ncol[7:0], sd.row + 8'd1)};
      end
    end
    foreach (words[i]) begin
      words[i].is_last = (i == words.size() - 1);
      nbr_expect_q.insert(nbr_expect_q.size(), words[i]);
    end
  endfunction

  // random seed, biased toward the chip edges of the current setting
  function automatic seed_t rand_seed();
    seed_t s;
    int    lc, lr, v;
    lc     = cfg_clamp(32'(cfg_cols), MAX_COLUMNS) - 1;
    lr     = cfg_clamp(32'(cfg_rows), MAX_ROWS) - 1;
    s.mod  = 6'($urandom);
    s.chip = 6'($urandom);
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 1);
      1: v = lc - 1 + $urandom_range(0, 3);
      2: v = $urandom_range(0, (lc < 255) ? lc + 1 : 255);
      default: v = $urandom_range(0, 255);
    endcase
    s.col = (v > 255) ? 8'd255 : v[7:0];
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 1);
      1: v = lr - 1 + $urandom_range(0, 3);
      2: v = $urandom_range(0, (lr < 255) ? lr + 1 : 255);
      default: v = $urandom_range(0, 255);
    endcase
    s.row = (v > 255) ? 8'd255 : v[7:0];
    return s;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  // register write, upper pwdata bits random since the block keeps only the field
  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    logic [31:0] keep;
    case (idx)
      REG_CHIPS_PER_SENSOR: keep = 32'h1f;
      REG_COLUMNS_PER_CHIP: keep = 32'h1ff;
      REG_ROWS_PER_CHIP:    keep = 32'h1ff;
      default:              keep = 32'h0;
    endcase
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= (val & keep) | ($urandom & ~keep);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_CHIPS_PER_SENSOR: cfg_chips = val[4:0];
      REG_COLUMNS_PER_CHIP: cfg_cols  = val[8:0];
      REG_ROWS_PER_CHIP:    cfg_rows  = val[8:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(logic [4:0] chips, logic [8:0] cols, logic [8:0] rows);
    cfg_write(REG_CHIPS_PER_SENSOR, 32'(chips));
    cfg_write(REG_COLUMNS_PER_CHIP, 32'(cols));
    cfg_write(REG_ROWS_PER_CHIP, 32'(rows));
    settings_cnt++;
  endtask

  // seeds with no neighbours leave no trace, so give the pipeline time to empty
  task automatic wait_drained();
    while (seed_q.size() != 0 || seed_pending || nbr_expect_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // seed driver
  always @(posedge clk_i or negedge rst_ni) begin : seed_driver
    logic        nxt_valid;
    logic [31:0] nxt_data;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      seed_pending  = 1'b0;
      src_gap       = 0;
    end else begin
      nxt_valid = s_axis_tvalid;
      nxt_data  = s_axis_tdata;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_neighbours(cur_seed);
        seeds_taken++;
        seed_pending = 1'b0;
        nxt_valid    = 1'b0;
      end
      if (!nxt_valid) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (seed_q.size() > 0) begin
          if (!no_idle && $urandom_range(0, 5) == 0) begin
            src_gap = $urandom_range(0, 8);
          end else begin
            cur_seed     = seed_q.pop_front();
            seed_pending = 1'b1;
            nxt_valid    = 1'b1;
            nxt_data     = {4'b0000, cur_seed};
          end
        end
      end
      s_axis_tvalid <= nxt_valid;
      s_axis_tdata  <= nxt_data;
    end
  end

  // sink ready: random bursts, plus one long hold on request
  always @(posedge clk_i or negedge rst_ni) begin : sink_ready
    logic rdy;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_gap      = 0;
      hold_left     = 0;
    end else begin
      rdy = 1'b0;
      if (hold_left > 0) begin
        hold_left--;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
      end else if (sink_gap > 0) begin
        sink_gap--;
      end else if (!no_idle && $urandom_range(0, 4) == 0) begin
        sink_gap = $urandom_range(0, 8);
      end else begin
        rdy = 1'b1;
      end
      m_axis_tready <= rdy;
    end
  end

  // neighbour word checker
  always @(posedge clk_i) begin : nbr_monitor
    nbr_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      words_seen++;
      if (nbr_expect_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, got %h last %b", $time,
                 m_axis_tdata, m_axis_tlast);
        error_count++;
      end else begin
        want = nbr_expect_q.pop_front();
        check_field("neighbour_module", 32'(want.mod),  32'(m_axis_tdata[5:0]));
        check_field("neighbour_chip",   32'(want.chip), 32'(m_axis_tdata[11:6]));
        check_field("neighbour_column", 32'(want.col),  32'(m_axis_tdata[19:12]));
        check_field("neighbour_row",    32'(want.row),  32'(m_axis_tdata[27:20]));
        check_field("padding",          0,              32'(m_axis_tdata[31:28]));
        check_field("last_neighbour",   32'(want.is_last), 32'(m_axis_tlast));
      end
    end
  end

  initial begin
    #10ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [4:0] chips;
    logic [8:0] cols, rows;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting: 3 chips per sensor, 256 x 256
    add_seed(seed_of(6'd0, 6'd0, 8'd0, 8'd0));         // sensor corner
    add_seed(seed_of(6'd5, 6'd1, 8'd100, 8'd100));     // full ring
    add_seed(seed_of(6'd63, 6'd63, 8'd255, 8'd255));   // next chip wraps to 0
    add_seed(seed_of(6'd42, 6'd1, 8'd0, 8'd17));       // left from chip 0
    add_seed(seed_of(6'd21, 6'd2, 8'd255, 8'd170));    // right sensor edge
    add_seed(seed_of(6'd10, 6'd2, 8'd0, 8'd0));
    add_seed(seed_of(6'd33, 6'd0, 8'd255, 8'd255));    // right into chip 1
    add_seed(seed_of(6'd7, 6'd3, 8'd128, 8'd0));       // sensor start again
    add_seed(seed_of(6'd55, 6'd62, 8'h55, 8'haa));
    add_seed(seed_of(6'h2a, 6'd15, 8'haa, 8'h55));
    wait_drained();

    // zero registers act as one: single pixel chips, lone sensors
    apply_setting(5'd0, 9'd0, 9'd0);
    add_seed(seed_of(6'd0, 6'd0, 8'd0, 8'd0));         // no neighbours
    add_seed(seed_of(6'd1, 6'd7, 8'd5, 8'd3));         // seed outside the chip
    add_seed(seed_of(6'd2, 6'd63, 8'd0, 8'd255));
    add_seed(seed_of(6'd3, 6'd5, 8'd255, 8'd0));
    wait_drained();

    // oversized sizes act as the maximum; unused register index is ignored
    apply_setting(5'd31, 9'd511, 9'd300);
    cfg_write(REG_UNUSED, $urandom);
    add_seed(seed_of(6'd0, 6'd30, 8'd255, 8'd255));    // last chip of sensor
    add_seed(seed_of(6'd0, 6'd31, 8'd255, 8'd255));    // first chip of next one
    add_seed(seed_of(6'd0, 6'd31, 8'd0, 8'd10));
    add_seed(seed_of(6'd0, 6'd32, 8'd0, 8'd10));
    add_seed(seed_of(6'd63, 6'd63, 8'd255, 8'd254));
    wait_drained();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == 0) begin
        chips = 5'd5;
        cols  = 9'd8;
        rows  = 9'd8;
      end else begin
        case ($urandom_range(0, 5))
          0: chips = 5'd0;
          1: chips = 5'd1;
          2: chips = 5'd2;
          3: chips = 5'($urandom_range(3, 8));
          4: chips = 5'd16;
          default: chips = 5'd31;
        endcase
        case ($urandom_range(0, 5))
          0: cols = 9'd2;
          1: cols = 9'd3;
          2: cols = 9'($urandom_range(4, 40));
          3: cols = 9'd255;
          4: cols = 9'd256;
          default: cols = 9'($urandom_range(257, 511));
        endcase
        case ($urandom_range(0, 5))
          0: rows = 9'd2;
          1: rows = 9'($urandom_range(0, 1));
          2: rows = 9'($urandom_range(3, 40));
          3: rows = 9'd255;
          4: rows = 9'd256;
          default: rows = 9'($urandom_range(257, 511));
        endcase
      end
      if (ph == RAND_PHASES - 1) no_idle = 1'b1;
      apply_setting(chips, cols, rows);
      for (int k = 0; k < PHASE_SEEDS; k++) add_seed(rand_seed());
      // starve the output while seeds keep coming so the block backs up
      if (ph == 2) hold_req = 1'b1;
      wait_drained();
    end

    $display("covered %0d seeds and %0d neighbour words over %0d register settings",
             seeds_taken, words_seen, settings_cnt);
    $display("including zero and oversized sizes, sensor edges and a %0d cycle output stall",
             HOLD_CYCLES);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
